// ----- hw/rtl/arh_pkg.sv -----
// shared constants for the auto-range histogram
package arh_pkg;
  localparam int MaxSamples = 1024;
  localparam int MaxBins = 64;
  localparam int AddrW = $clog2(MaxSamples);
  localparam int CntW = AddrW + 1;
  localparam int BinW = $clog2(MaxBins);
  localparam int BinCntW = 7;
  localparam int TotW = 11;
  localparam logic [TotW-1:0] TotMax = 11'd2047;
  localparam logic [BinCntW-1:0] DefaultBins = 7'd10;
endpackage

// ----- hw/rtl/arh_div.sv -----
// restoring divider, one quotient bit per cycle
module arh_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [23:0] num,
  input  logic [16:0] den,
  output logic        done,
  output logic [23:0] quo
);
  logic [4:0]  step_r;
  logic        run_r;
  logic [23:0] q_r;
  logic [17:0] rem_r;
  logic [16:0] den_r;
  logic [17:0] sh;
  logic        run_done;

  assign sh = {rem_r[16:0], q_r[23]};
  assign run_done = run_r && (step_r == 5'd23);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= '0;
      done   <= 1'b0;
    end else begin
      done <= run_done;
      if (go) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_done) begin
        run_r <= 1'b0;
      end else if (run_r) begin
        step_r <= step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_r <= sh - {1'b0, den_r};
        q_r   <= {q_r[22:0], 1'b1};
      end else begin
        rem_r <= sh;
        q_r   <= {q_r[22:0], 1'b0};
      end
    end
  end

  assign quo = q_r;
endmodule

// ----- hw/rtl/auto_range_histogram_core.sv -----
// auto-range histogram: sample store, binning pass and bin readout
//
// usage: drive in_sample/in_last with start; a beat is taken when start is
// high and busy is low. samples load one per cycle into a 1024-entry store
// while min and max are tracked. the beat with in_last starts the pass:
// all count entries are cleared, then each stored sample is read and binned
// by a serial divider (skipped when min equals max), a read-modify-write of
// the count memory. then one result per bin is shown for one cycle on
// out_valid, each bin needing one divider run for its center (none when min
// equals max). busy stays high from the last beat until the final bin is
// shown. cfg_valid/cfg_ready writes bin_count, read at the last beat; reset
// value is 10. results cannot be stalled. reset clears control state; the
// store contents stay undefined until written.
module auto_range_histogram_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_sample,
  input  logic               in_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_bin_count,
  output logic               out_valid,
  output logic signed [15:0] out_bin_center,
  output logic [10:0]        out_bin_total,
  output logic               out_final_bin,
  output logic               out_dropped
);
  typedef enum logic [3:0] {
    S_LOAD, S_CLR, S_RD, S_RDW, S_DIV, S_DIVW, S_INC, S_CRD, S_CDIV, S_CDIVW, S_EMIT
  } state_t;

  localparam int BinIdxW = arh_pkg::BinW;

  state_t state_r;
  logic [arh_pkg::BinCntW-1:0] bins_cfg_r, bins_r;
  logic signed [15:0] min_r, max_r;
  logic [arh_pkg::CntW-1:0] total_r, idx_r;
  logic ovf_r;
  logic [arh_pkg::BinW:0] bin_r;

  logic [15:0] store [arh_pkg::MaxSamples];
  logic [15:0] srd_r;
  logic [arh_pkg::TotW-1:0] counts [arh_pkg::MaxBins];
  logic [arh_pkg::TotW-1:0] crd_r;

  logic        div_go, div_done;
  logic [23:0] div_num, div_quo;
  logic [16:0] div_den;
  logic [16:0] range;
  logic [16:0] off;
  logic [BinIdxW-1:0] wb;

  logic        take;
  logic [arh_pkg::BinCntW-1:0] bins_eff;
  logic signed [17:0] center;
  logic [arh_pkg::BinW-1:0] bidx;

  assign take = start && !busy;
  assign busy = (state_r != S_LOAD);
  assign cfg_ready = 1'b1;
  assign range = 17'($signed({max_r[15], max_r}) - $signed({min_r[15], min_r}));
  assign off = 17'($signed({srd_r[15], srd_r}) - $signed({min_r[15], min_r}));
  assign bins_eff = (bins_cfg_r == '0) ? 7'd1 :
                    (bins_cfg_r > 7'(arh_pkg::MaxBins)) ? 7'(arh_pkg::MaxBins) : bins_cfg_r;
  assign bidx = bin_r[arh_pkg::BinW-1:0];
  assign wb = (range == '0) ? '0 :
              (div_quo >= 24'(bins_r)) ? BinIdxW'(bins_r - 7'd1) : div_quo[BinIdxW-1:0];

  always_comb begin
    div_go  = 1'b0;
    div_num = '0;
    div_den = range;
    if (state_r == S_DIV) begin
      div_go  = 1'b1;
      div_num = 24'(off) * 24'(bins_r);
    end else if (state_r == S_CDIV) begin
      div_go  = 1'b1;
      div_num = 24'(range) * 24'({bin_r, 1'b1});
      div_den = {9'd0, bins_r, 1'b0};
    end
  end

  arh_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  always_comb begin
    if (range == '0)
      center = 18'($signed({{2{min_r[15]}}, min_r}) + $signed({1'b0, bin_r, 8'h80}));
    else
      center = 18'($signed({{2{min_r[15]}}, min_r}) + $signed({1'b0, div_quo[16:0]}));
  end

  always_ff @(posedge clk) begin
    if (take && total_r < arh_pkg::CntW'(arh_pkg::MaxSamples))
      store[total_r[arh_pkg::AddrW-1:0]] <= in_sample;
    srd_r <= store[idx_r[arh_pkg::AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) counts[bidx] <= '0;
    else if (state_r == S_INC && crd_r != arh_pkg::TotMax) counts[wb] <= crd_r + 11'd1;
    crd_r <= counts[(state_r == S_DIVW) ? wb : bidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      bins_cfg_r <= arh_pkg::DefaultBins;
      bins_r     <= arh_pkg::DefaultBins;
      min_r      <= '0;
      max_r      <= '0;
      total_r    <= '0;
      idx_r      <= '0;
      ovf_r      <= 1'b0;
      bin_r      <= '0;
      out_valid  <= 1'b0;
      out_bin_center <= '0;
      out_bin_total  <= '0;
      out_final_bin  <= 1'b0;
      out_dropped    <= 1'b0;
    end else begin
      out_valid <= (state_r == S_EMIT);
      if (cfg_valid) bins_cfg_r <= cfg_bin_count;
      case (state_r)
        S_LOAD: if (take) begin
          if (total_r < arh_pkg::CntW'(arh_pkg::MaxSamples)) begin
            total_r <= total_r + 1'b1;
            if (total_r == '0) begin
              min_r <= in_sample; max_r <= in_sample;
            end else begin
              if (in_sample < min_r) min_r <= in_sample;
              if (in_sample > max_r) max_r <= in_sample;
            end
          end else ovf_r <= 1'b1;
          if (in_last) begin
            bins_r <= bins_eff;
            bin_r  <= '0;
            state_r <= S_CLR;
          end
        end
        S_CLR: begin
          if (bin_r == 7'(arh_pkg::MaxBins - 1)) begin
            idx_r <= '0;
            state_r <= (total_r == '0) ? S_CRD : S_RD;
            bin_r <= '0;
          end else bin_r <= bin_r + 1'b1;
        end
        S_RD:   state_r <= S_RDW;
        S_RDW:  state_r <= (range == '0) ? S_INC : S_DIV;
        S_DIV:  state_r <= S_DIVW;
        S_DIVW: if (div_done) state_r <= S_INC;
        S_INC: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r + 1'b1 == total_r) begin
            bin_r <= '0;
            state_r <= S_CRD;
          end else state_r <= S_RD;
        end
        S_CRD:  state_r <= (range == '0) ? S_EMIT : S_CDIV;
        S_CDIV: state_r <= S_CDIVW;
        S_CDIVW: if (div_done) state_r <= S_EMIT;
        S_EMIT: begin
          out_bin_center <= (center > 18'sd32767) ? 16'sd32767 : center[15:0];
          out_bin_total  <= crd_r;
          out_final_bin  <= (bin_r == bins_r - 7'd1);
          out_dropped    <= ovf_r;
          if (bin_r == bins_r - 7'd1) begin
            total_r <= '0; ovf_r <= 1'b0; min_r <= '0; max_r <= '0;
            state_r <= S_LOAD;
          end else begin
            bin_r <= bin_r + 1'b1;
            state_r <= S_CRD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> $past(state_r) == S_EMIT)
    else $error("result without emit");
  assert property (@(posedge clk) disable iff (!rst_n) total_r <= arh_pkg::CntW'(arh_pkg::MaxSamples))
    else $error("store fill past capacity");
  assert property (@(posedge clk) disable iff (!rst_n) (out_valid && out_final_bin) |-> !busy)
    else $error("busy after final bin");
endmodule

// ----- tb/tb_auto_range_histogram_core.sv -----
// self-checking testbench for the auto-range histogram core
module tb_auto_range_histogram_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] center;
    logic [10:0]        total;
    logic               final_bin;
    logic               dropped;
  } bin_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_sample = '0;
  logic in_last = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_bin_count = '0;
  logic out_valid;
  logic signed [15:0] out_bin_center;
  logic [10:0] out_bin_total;
  logic out_final_bin;
  logic out_dropped;

  auto_range_histogram_core dut (.*);

  // predictor state
  logic signed [15:0] set_samples[arh_pkg::MaxSamples];
  int set_len;
  int set_min, set_max;
  bit set_overflow;
  logic [6:0] bins_reg;
  bin_beat_t expected_bins[$];

  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic predict_sample(input logic signed [15:0] x, input logic lst);
    int nb, range, off, b, c;
    int counts[arh_pkg::MaxBins];
    bin_beat_t r;
    if (set_len < arh_pkg::MaxSamples) begin
      if (set_len == 0) begin
        set_min = x;
        set_max = x;
      end else begin
        if (x < set_min) set_min = x;
        if (x > set_max) set_max = x;
      end
      set_samples[set_len] = x;
      set_len++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!lst) return;
    nb = bins_reg;
    if (nb < 1) nb = 1;
    if (nb > arh_pkg::MaxBins) nb = arh_pkg::MaxBins;
    range = set_max - set_min;
    foreach (counts[i]) counts[i] = 0;
    for (int i = 0; i < set_len; i++) begin
      off = int'(set_samples[i]) - set_min;
      b = 0;
      if (range != 0) begin
        b = int'((longint'(off) * nb) / range);
        if (b > nb - 1) b = nb - 1;
      end
      if (counts[b] < 2047) counts[b]++;
    end
    for (int k = 0; k < nb; k++) begin
      if (range != 0) c = set_min + int'((longint'(range) * (2 * k + 1)) / (2 * nb));
      else c = set_min + 128 * (2 * k + 1);
      if (c > 32767) c = 32767;
      r.center = c[15:0];
      r.total = counts[k][10:0];
      r.final_bin = (k == nb - 1);
      r.dropped = set_overflow;
      expected_bins = {expected_bins, r};
    end
    set_len = 0;
    set_overflow = 1'b0;
    set_min = 0;
    set_max = 0;
  endtask

  task automatic random_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [15:0] x, input logic lst);
    start <= 1'b1;
    in_sample <= x;
    in_last <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_sample(x, lst);
    start <= 1'b0;
    @(posedge clk);
    random_gap();
  endtask

  task automatic drain();
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_bins(input logic [6:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_bin_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    bins_reg = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_bins();
    send_sample(16'sh0100, 1'b0);
    send_sample(-16'sh0100, 1'b0);
    send_sample(16'sh0033, 1'b1);
  endtask

  task automatic test_extremes();
    write_bins(7'd64);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    write_bins(7'd1);
    send_sample(16'sh1234, 1'b0);
    send_sample(16'shedcb, 1'b1);
  endtask

  task automatic test_zero_range();
    write_bins(7'd40);
    send_sample(16'sh7000, 1'b0);
    send_sample(16'sh7000, 1'b1);
    send_sample(-16'sh5, 1'b1);
  endtask

  task automatic test_bin_clamp();
    write_bins(7'd0);
    send_sample(16'sh0010, 1'b0);
    send_sample(16'sh0020, 1'b1);
    write_bins(7'd127);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shaaaa, 1'b1);
  endtask

  task automatic test_random();
    int n, len;
    logic signed [15:0] x;
    logic [6:0] nb;
    int base, spread;
    n = 0;
    while (n < 200) begin
      nb = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(1, 12));
      write_bins(nb);
      len = $urandom_range(1, 12);
      base = $urandom_range(0, 65535) - 32768;
      spread = $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 2000);
      if ($urandom_range(0, 6) == 0) begin
        // long stretch with no gaps, then the sender holds until results finish
        for (int i = 0; i < len; i++) begin
          start <= 1'b1;
          x = 16'(base + $urandom_range(0, spread));
          in_sample <= x;
          in_last <= (i == len - 1);
          @(posedge clk);
          while (busy) @(posedge clk);
          predict_sample(x, i == len - 1);
        end
        start <= 1'b0;
      end else begin
        for (int i = 0; i < len; i++)
          send_sample(16'(base + $urandom_range(0, spread)), i == len - 1);
      end
      n += len;
    end
  endtask

  always @(posedge clk) begin
    bin_beat_t e;
    if (rst_n && out_valid) begin
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat center=%0d", out_bin_center);
      end else begin
        e = expected_bins.pop_front();
        if (out_bin_center !== e.center || out_bin_total !== e.total ||
            out_final_bin !== e.final_bin || out_dropped !== e.dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp c=%0d t=%0d f=%0b d=%0b got c=%0d t=%0d f=%0b d=%0b",
                     e.center, e.total, e.final_bin, e.dropped, out_bin_center,
                     out_bin_total, out_final_bin, out_dropped);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000 && !timed_out) begin
      timed_out = 1'b1;
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    set_len = 0;
    set_min = 0;
    set_max = 0;
    set_overflow = 1'b0;
    bins_reg = arh_pkg::DefaultBins;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_bins();
    test_extremes();
    test_zero_range();
    test_bin_clamp();
    test_random();
    drain();
    if (mismatches == 0 && expected_bins.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
